@@ hdl/assert_macros.svh @@
// Assertion macros used by the top RTL file of the receive block reassembly.
// Assertions compile only outside synthesis; the synthesis variants are empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ERBR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define ERBR_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ERBR_ASSERT(lbl, clk, rst_n, prop)
`define ERBR_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hdl/erbr_pkg.sv @@
// Package of the receive block reassembly: item codes, constants, result and pool types.
// No dependencies.
package erbr_pkg;

  localparam int POOL_DEPTH_DEF  = 16;
  localparam int ENTRY_W         = 48;
  localparam int START_MAX_BYTES = 64;

  localparam logic [1:0] MODE_STATUS = 2'd0;
  localparam logic [1:0] MODE_DATA   = 2'd1;
  localparam logic [1:0] MODE_BUFFER = 2'd2;

  localparam logic [2:0] REASON_FCS_OK   = 3'd0;
  localparam logic [2:0] REASON_FCS_BAD  = 3'd1;
  localparam logic [2:0] REASON_ODD_NYB  = 3'd2;
  localparam logic [2:0] REASON_BLK_DONE = 3'd3;
  localparam logic [2:0] REASON_OVERRUN  = 3'd4;
  localparam logic [2:0] REASON_FRAMING  = 3'd5;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic        deliver_valid;
    logic [31:0] deliver_address;
    logic [15:0] deliver_length;
    logic        packet_dropped;
    logic        pool_full;
  } erbr_result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } erbr_pool_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } erbr_pool_sts_t;

endpackage

@@ hdl/erbr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module erbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/erbr_pool.sv @@
// Spare buffer stack: RAM holds the entries, a count register tracks the top.
// Depends on erbr_pkg and erbr_ram.
module erbr_pool
  import erbr_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  erbr_pool_cmd_t       cmd,
  input  logic [ENTRY_W-1:0]   push_entry,
  output erbr_pool_sts_t       sts,
  output logic [ENTRY_W-1:0]   top_entry
);

  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int IW = $clog2(POOL_DEPTH);

  logic [CW-1:0]      count_r, count_nxt, rd_cnt;
  logic               fwd_valid_r;
  logic [ENTRY_W-1:0] fwd_data_r;
  logic [ENTRY_W-1:0] rd_data;

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop && (count_r != '0)) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // read always targets the top after this cycle's update
  assign rd_cnt = count_nxt - CW'(1);

  erbr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(POOL_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (count_r[IW-1:0]),
    .wr_data (push_entry),
    .rd_addr (rd_cnt[IW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      fwd_valid_r <= cmd.push;
    end
    fwd_data_r <= push_entry;
  end

  // a push writes the very entry being read; take it from the bypass
  assign top_entry = fwd_valid_r ? fwd_data_r : rd_data;
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(POOL_DEPTH));

endmodule

@@ hdl/erbr_out_buf.sv @@
// Two-entry result buffer: output register plus skid register.
// Depends on erbr_pkg.
module erbr_out_buf
  import erbr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  erbr_result_t push_data,
  output logic         can_take,
  output logic         out_valid,
  output erbr_result_t out_data,
  input  logic         out_ready
);

  logic         main_valid_r, skid_valid_r;
  erbr_result_t main_r, skid_r;
  logic         take;

  assign take = main_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid_r) begin
          main_r       <= skid_r;
          skid_valid_r <= 1'b0;
        end else if (push) begin
          main_r <= push_data;
        end else begin
          main_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (!main_valid_r) begin
          main_r       <= push_data;
          main_valid_r <= 1'b1;
        end else begin
          skid_r       <= push_data;
          skid_valid_r <= 1'b1;
        end
      end
    end
  end

  assign can_take  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

@@ hdl/eth_rx_block_reassembly.sv @@
// Receive block reassembly: input item decode, packet state and result build.
// Depends on erbr_pkg, erbr_pool, erbr_out_buf and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per handshake: a status
//   word, a data word or a buffer to add to the pool, chosen by in_mode.
//   Result channel (out_valid/out_ready) returns exactly one result per item,
//   in order: a store request, a delivered packet, drop and pool-full flags.
//   Each result is registered in the output buffer as its item is accepted.
//   Throughput: one item per cycle while in_ready is high. The pool's top entry
//   comes from the stack RAM's registered read, re-addressed every cycle to the
//   top after the current update, with a bypass register for a just-pushed entry.
//   Stall: a two-entry output buffer holds results; in_ready drops only when
//   both entries are full, and rises again the cycle after out_ready takes one.
//   Reset (rst_n low, synchronous): pool empty, no head buffer, no packet,
//   output buffer empty. The stack RAM is not cleared; only written entries
//   are ever used. Items are taken as soon as reset is released.
`include "assert_macros.svh"
module eth_rx_block_reassembly
  import erbr_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_status_reason,
  input  logic [7:0]  in_block_bytes,
  input  logic [15:0] in_packet_bytes,
  input  logic [31:0] in_data_word,
  input  logic [31:0] in_buffer_address,
  input  logic [15:0] in_buffer_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_valid,
  output logic [31:0] out_write_address,
  output logic [31:0] out_write_data,
  output logic        out_deliver_valid,
  output logic [31:0] out_deliver_address,
  output logic [15:0] out_deliver_length,
  output logic        out_packet_dropped,
  output logic        out_pool_full
);

  logic        head_present_r, head_present_nxt;
  logic [31:0] head_address_r, head_address_nxt;
  logic [15:0] head_capacity_r, head_capacity_nxt;
  logic        packet_active_r, packet_active_nxt;
  logic [15:0] received_length_r, received_length_nxt;
  logic [31:0] block_write_address_r, block_write_address_nxt;
  logic [6:0]  words_left_r, words_left_nxt;
  logic        block_keeps_data_r, block_keeps_data_nxt;
  logic [2:0]  pending_reason_r, pending_reason_nxt;

  logic               in_fire;
  erbr_result_t       res;
  erbr_result_t       out_res;
  erbr_pool_cmd_t     pool_cmd;
  erbr_pool_sts_t     pool_sts;
  logic [ENTRY_W-1:0] top_entry;

  logic        act;
  logic [2:0]  act_reason;
  logic [6:0]  words;
  logic        keep;
  logic [31:0] base;
  logic [16:0] sum;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    head_present_nxt        = head_present_r;
    head_address_nxt        = head_address_r;
    head_capacity_nxt       = head_capacity_r;
    packet_active_nxt       = packet_active_r;
    received_length_nxt     = received_length_r;
    block_write_address_nxt = block_write_address_r;
    words_left_nxt          = words_left_r;
    block_keeps_data_nxt    = block_keeps_data_r;
    pending_reason_nxt      = pending_reason_r;
    res        = '0;
    pool_cmd   = '0;
    act        = 1'b0;
    act_reason = REASON_BLK_DONE;
    words      = 7'(({1'b0, in_block_bytes} + 9'd3) >> 2);
    keep       = 1'b0;
    base       = '0;
    sum        = {1'b0, received_length_r} + {9'b0, in_block_bytes};

    if (in_fire) begin
      unique case (in_mode)
        MODE_STATUS: begin
          if (in_packet_bytes <= 16'(START_MAX_BYTES)) begin
            // start or restart in the head buffer
            if (!packet_active_r && head_present_r) begin
              packet_active_nxt = 1'b1;
            end
            if (packet_active_nxt) begin
              keep                = 1'b1;
              base                = head_address_r;
              received_length_nxt = in_packet_bytes;
            end
          end else if (packet_active_r) begin
            base                = head_address_r + {16'b0, received_length_r};
            keep                = 1'b1;
            received_length_nxt = sum[15:0];
            if (sum > {1'b0, head_capacity_r}) begin
              packet_active_nxt  = 1'b0;
              keep               = 1'b0;
              res.packet_dropped = 1'b1;
            end
          end
          if (words == '0) begin
            words_left_nxt          = '0;
            block_keeps_data_nxt    = 1'b0;
            block_write_address_nxt = '0;
            pending_reason_nxt      = REASON_BLK_DONE;
            act                     = 1'b1;
            act_reason              = in_status_reason;
          end else begin
            words_left_nxt          = words;
            block_keeps_data_nxt    = keep;
            block_write_address_nxt = keep ? base : 32'b0;
            pending_reason_nxt      = in_status_reason;
          end
        end
        MODE_DATA: begin
          if (words_left_r != '0) begin
            if (block_keeps_data_r) begin
              res.write_valid         = 1'b1;
              res.write_address       = block_write_address_r;
              res.write_data          = in_data_word;
              block_write_address_nxt = block_write_address_r + 32'd4;
            end
            words_left_nxt = words_left_r - 7'd1;
            if (words_left_r == 7'd1) begin
              block_keeps_data_nxt = 1'b0;
              pending_reason_nxt   = REASON_BLK_DONE;
              act                  = 1'b1;
              act_reason           = pending_reason_r;
            end
          end
        end
        MODE_BUFFER: begin
          if (!head_present_r) begin
            head_present_nxt  = 1'b1;
            head_address_nxt  = in_buffer_address;
            head_capacity_nxt = in_buffer_bytes;
          end else if (pool_sts.full) begin
            res.pool_full = 1'b1;
          end else begin
            pool_cmd.push = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (act) begin
      unique case (act_reason)
        REASON_FCS_OK: begin
          if (packet_active_nxt) begin
            res.deliver_valid   = 1'b1;
            res.deliver_address = head_address_r;
            res.deliver_length  = received_length_nxt;
            packet_active_nxt   = 1'b0;
            pool_cmd.pop        = 1'b1;
            if (!pool_sts.empty) begin
              head_present_nxt  = 1'b1;
              head_address_nxt  = top_entry[47:16];
              head_capacity_nxt = top_entry[15:0];
            end else begin
              head_present_nxt  = 1'b0;
              head_address_nxt  = '0;
              head_capacity_nxt = '0;
            end
          end
        end
        REASON_FCS_BAD, REASON_ODD_NYB, REASON_OVERRUN, REASON_FRAMING: begin
          if (packet_active_nxt) begin
            res.packet_dropped = 1'b1;
          end
          packet_active_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_present_r        <= 1'b0;
      head_address_r        <= '0;
      head_capacity_r       <= '0;
      packet_active_r       <= 1'b0;
      received_length_r     <= '0;
      block_write_address_r <= '0;
      words_left_r          <= '0;
      block_keeps_data_r    <= 1'b0;
      pending_reason_r      <= REASON_BLK_DONE;
    end else begin
      head_present_r        <= head_present_nxt;
      head_address_r        <= head_address_nxt;
      head_capacity_r       <= head_capacity_nxt;
      packet_active_r       <= packet_active_nxt;
      received_length_r     <= received_length_nxt;
      block_write_address_r <= block_write_address_nxt;
      words_left_r          <= words_left_nxt;
      block_keeps_data_r    <= block_keeps_data_nxt;
      pending_reason_r      <= pending_reason_nxt;
    end
  end

  erbr_pool #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (pool_cmd),
    .push_entry ({in_buffer_address, in_buffer_bytes}),
    .sts        (pool_sts),
    .top_entry  (top_entry)
  );

  erbr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_data  (out_res),
    .out_ready (out_ready)
  );

  assign out_write_valid     = out_res.write_valid;
  assign out_write_address   = out_res.write_address;
  assign out_write_data      = out_res.write_data;
  assign out_deliver_valid   = out_res.deliver_valid;
  assign out_deliver_address = out_res.deliver_address;
  assign out_deliver_length  = out_res.deliver_length;
  assign out_packet_dropped  = out_res.packet_dropped;
  assign out_pool_full       = out_res.pool_full;

  // spares only exist behind a head buffer
  `ERBR_NEVER(a_spare_without_head, clk, rst_n, !pool_sts.empty && !head_present_r)
  `ERBR_NEVER(a_packet_without_head, clk, rst_n, packet_active_r && !head_present_r)
  `ERBR_NEVER(a_keep_without_words, clk, rst_n, block_keeps_data_r && (words_left_r == '0))
  // input stalls only while results are held
  `ERBR_ASSERT(a_stall_has_result, clk, rst_n, !in_ready |-> out_valid)

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for eth_rx_block_reassembly: directed table, then random
// packet traffic with buffer-pool churn, checked against an in-bench predictor.
// Depends on erbr_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_top
  import erbr_pkg::*;
();

  localparam int POOL_SLOTS = POOL_DEPTH_DEF;
  localparam int ITEMS_TARGET = 1600;
  localparam int DRAIN_LIMIT = 4000;
  localparam int TAIL_CYCLES = 4;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] REASON_RSVD6 = 3'd6;
  localparam logic [2:0] REASON_RSVD7 = 3'd7;
  localparam int PLAN_LEN = 23;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  reason;
    logic [7:0]  blk_bytes;
    logic [15:0] pkt_bytes;
    logic [31:0] word;
    logic [31:0] buf_addr;
    logic [15:0] buf_bytes;
  } rx_item_t;

  typedef struct {
    rx_item_t item;
    bit       quiet;  // result is all zero, typed in directly
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [2:0]  in_status_reason;
  logic [7:0]  in_block_bytes;
  logic [15:0] in_packet_bytes;
  logic [31:0] in_data_word;
  logic [31:0] in_buffer_address;
  logic [15:0] in_buffer_bytes;
  logic        out_valid;
  logic        out_ready;
  logic        out_write_valid;
  logic [31:0] out_write_address;
  logic [31:0] out_write_data;
  logic        out_deliver_valid;
  logic [31:0] out_deliver_address;
  logic [15:0] out_deliver_length;
  logic        out_packet_dropped;
  logic        out_pool_full;

  eth_rx_block_reassembly #(.POOL_DEPTH(POOL_SLOTS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_status_reason   (in_status_reason),
    .in_block_bytes     (in_block_bytes),
    .in_packet_bytes    (in_packet_bytes),
    .in_data_word       (in_data_word),
    .in_buffer_address  (in_buffer_address),
    .in_buffer_bytes    (in_buffer_bytes),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_write_valid    (out_write_valid),
    .out_write_address  (out_write_address),
    .out_write_data     (out_write_data),
    .out_deliver_valid  (out_deliver_valid),
    .out_deliver_address(out_deliver_address),
    .out_deliver_length (out_deliver_length),
    .out_packet_dropped (out_packet_dropped),
    .out_pool_full      (out_pool_full)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("tb_top failed");
    $finish;
  end

  // Predicted state of the reassembly engine
  logic        hd_present = 1'b0;
  logic [31:0] hd_addr = '0;
  logic [15:0] hd_cap = '0;
  logic [31:0] spare_addr [POOL_SLOTS];
  logic [15:0] spare_cap [POOL_SLOTS];
  int          spare_cnt = 0;
  logic        pkt_open = 1'b0;
  logic [15:0] pkt_len = '0;
  logic [31:0] blk_addr = '0;
  logic [6:0]  words_due = '0;
  logic        blk_keep = 1'b0;
  logic [2:0]  blk_reason = REASON_BLK_DONE;

  erbr_result_t rx_expected [$];
  plan_row_t    dir_plan [PLAN_LEN];
  int n_errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_stored = 0;
  int n_delivered = 0;
  int n_dropped = 0;
  int n_refused = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", n_results, name, got, want));
  endtask

  function automatic erbr_result_t settle_reason(input logic [2:0] reason,
                                                 input erbr_result_t r);
    case (reason)
      REASON_FCS_OK: begin
        if (pkt_open) begin
          r.deliver_valid   = 1'b1;
          r.deliver_address = hd_addr;
          r.deliver_length  = pkt_len;
          pkt_open = 1'b0;
          // head leaves with the packet; next spare takes its place
          if (spare_cnt > 0) begin
            spare_cnt--;
            hd_addr = spare_addr[spare_cnt];
            hd_cap  = spare_cap[spare_cnt];
          end else begin
            hd_present = 1'b0;
            hd_addr = '0;
            hd_cap  = '0;
          end
        end
      end
      REASON_FCS_BAD, REASON_ODD_NYB, REASON_OVERRUN, REASON_FRAMING: begin
        if (pkt_open) r.packet_dropped = 1'b1;
        pkt_open = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic erbr_result_t predict_rx(input rx_item_t it);
    erbr_result_t r;
    logic [8:0]  span;
    logic [6:0]  words;
    logic [16:0] sum;
    logic        keep;
    logic [31:0] base;
    r = '0;
    case (it.mode)
      MODE_STATUS: begin
        span  = {1'b0, it.blk_bytes} + 9'd3;
        words = span[8:2];
        keep  = 1'b0;
        base  = '0;
        if (it.pkt_bytes <= START_MAX_BYTES) begin
          if (!pkt_open && hd_present) pkt_open = 1'b1;
          if (pkt_open) begin
            keep = 1'b1;
            base = hd_addr;
            pkt_len = it.pkt_bytes;
          end
        end else if (pkt_open) begin
          sum  = {1'b0, pkt_len} + {9'd0, it.blk_bytes};
          base = hd_addr + {16'd0, pkt_len};
          keep = 1'b1;
          pkt_len = sum[15:0];
          if (sum > {1'b0, hd_cap}) begin
            pkt_open = 1'b0;
            keep = 1'b0;
            r.packet_dropped = 1'b1;
          end
        end
        // a new status forgets whatever is left of the previous block
        if (words == 0) begin
          words_due  = '0;
          blk_keep   = 1'b0;
          blk_addr   = '0;
          blk_reason = REASON_BLK_DONE;
          r = settle_reason(it.reason, r);
        end else begin
          words_due  = words;
          blk_keep   = keep;
          blk_addr   = keep ? base : '0;
          blk_reason = it.reason;
        end
      end
      MODE_DATA: begin
        if (words_due != 0) begin
          if (blk_keep) begin
            r.write_valid   = 1'b1;
            r.write_address = blk_addr;
            r.write_data    = it.word;
            blk_addr = blk_addr + 32'd4;
          end
          words_due--;
          if (words_due == 0) begin
            blk_keep = 1'b0;
            r = settle_reason(blk_reason, r);
            blk_reason = REASON_BLK_DONE;
          end
        end
      end
      MODE_BUFFER: begin
        if (!hd_present) begin
          hd_present = 1'b1;
          hd_addr = it.buf_addr;
          hd_cap  = it.buf_bytes;
        end else if (spare_cnt >= POOL_SLOTS) begin
          r.pool_full = 1'b1;
        end else begin
          spare_addr[spare_cnt] = it.buf_addr;
          spare_cap[spare_cnt]  = it.buf_bytes;
          spare_cnt++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic plan_row_t mk_row(input logic [1:0] mode, input logic [2:0] reason,
                                       input logic [7:0] bb, input logic [15:0] pb,
                                       input logic [31:0] word, input logic [31:0] addr,
                                       input logic [15:0] cap, input bit quiet);
    plan_row_t row;
    row.item.mode      = mode;
    row.item.reason    = reason;
    row.item.blk_bytes = bb;
    row.item.pkt_bytes = pb;
    row.item.word      = word;
    row.item.buf_addr  = addr;
    row.item.buf_bytes = cap;
    row.quiet = quiet;
    return row;
  endfunction

  // all fields but the mode random; caller overrides the ones that matter
  function automatic rx_item_t fresh_item(input logic [1:0] mode);
    rx_item_t it;
    it.mode      = mode;
    it.reason    = 3'($urandom);
    it.blk_bytes = 8'($urandom);
    it.pkt_bytes = 16'($urandom);
    it.word      = $urandom;
    it.buf_addr  = $urandom;
    it.buf_bytes = 16'($urandom);
    return it;
  endfunction

  function automatic logic [7:0] pick_bytes();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 32));
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input rx_item_t it, input bit quiet);
    int gap;
    erbr_result_t pred;
    gap = (((n_items / 128) % 4) == 1) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_mode           <= it.mode;
    in_status_reason  <= it.reason;
    in_block_bytes    <= it.blk_bytes;
    in_packet_bytes   <= it.pkt_bytes;
    in_data_word      <= it.word;
    in_buffer_address <= it.buf_addr;
    in_buffer_bytes   <= it.buf_bytes;
    do @(posedge clk); while (!in_ready);
    if (it.mode != MODE_UNUSED && !(it.mode == MODE_DATA && words_due == 0)) n_items++;
    pred = predict_rx(it);
    n_stored    += pred.write_valid;
    n_delivered += pred.deliver_valid;
    n_dropped   += pred.packet_dropped;
    n_refused   += pred.pool_full;
    rx_expected.push_back(quiet ? erbr_result_t'('0) : pred);
    @(negedge clk);
  endtask

  task automatic send_block(input logic [2:0] reason, input logic [7:0] bb,
                            input logic [15:0] pb, input int cut);
    rx_item_t it;
    int n;
    it = fresh_item(MODE_STATUS);
    it.reason    = reason;
    it.blk_bytes = bb;
    it.pkt_bytes = pb;
    send_item(it, 1'b0);
    n = (bb + 3) / 4 - cut;
    for (int i = 0; i < n; i++) send_item(fresh_item(MODE_DATA), 1'b0);
  endtask

  task automatic add_buffer();
    rx_item_t it;
    it = fresh_item(MODE_BUFFER);
    if ($urandom_range(0, 7) != 0) it.buf_bytes = 16'($urandom_range(40, 300));
    send_item(it, 1'b0);
  endtask

  // result side
  initial begin
    int stall;
    erbr_result_t want;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = (((n_results / 100) % 4) == 2) ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (rx_expected.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = rx_expected.pop_front();
        check_field("write_valid", out_write_valid, want.write_valid);
        check_field("write_address", out_write_address, want.write_address);
        check_field("write_data", out_write_data, want.write_data);
        check_field("deliver_valid", out_deliver_valid, want.deliver_valid);
        check_field("deliver_address", out_deliver_address, want.deliver_address);
        check_field("deliver_length", out_deliver_length, want.deliver_length);
        check_field("packet_dropped", out_packet_dropped, want.packet_dropped);
        check_field("pool_full", out_pool_full, want.pool_full);
      end
      n_results++;
      @(negedge clk);
    end
  end

  // stimulus side
  initial begin
    int sel;
    int nblk;
    int cut;
    int waited;
    logic [2:0] rsn;
    logic [15:0] pb;
    rx_item_t it;

    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_mode           = MODE_STATUS;
    in_status_reason  = REASON_FCS_OK;
    in_block_bytes    = '0;
    in_packet_bytes   = '0;
    in_data_word      = '0;
    in_buffer_address = '0;
    in_buffer_bytes   = '0;

    // start with no buffer, then build a pool and walk the reasons
    dir_plan[0]  = mk_row(MODE_STATUS, REASON_FCS_OK, 8'd0, 16'd0, '0, '0, '0, 1'b1);
    dir_plan[1]  = mk_row(MODE_DATA, REASON_FCS_OK, 8'd0, 16'd0, '1, '0, '0, 1'b1);
    dir_plan[2]  = mk_row(MODE_UNUSED, REASON_RSVD7, '1, '1, '1, '1, '1, 1'b1);
    dir_plan[3]  = mk_row(MODE_STATUS, REASON_BLK_DONE, 8'd5, 16'd10, '0, '0, '0, 1'b0);
    dir_plan[4]  = mk_row(MODE_DATA, REASON_FCS_OK, 8'd0, 16'd0, '1, '0, '0, 1'b0);
    dir_plan[5]  = mk_row(MODE_DATA, REASON_FCS_OK, 8'd0, 16'd0, '0, '0, '0, 1'b0);
    dir_plan[6]  = mk_row(MODE_BUFFER, REASON_FCS_OK, 8'd0, 16'd0, '0, 32'hffff_fff0,
                          16'hffff, 1'b0);
    dir_plan[7]  = mk_row(MODE_BUFFER, REASON_FCS_OK, 8'd0, 16'd0, '0, '0, '0, 1'b0);
    dir_plan[8]  = mk_row(MODE_BUFFER, REASON_FCS_OK, 8'd0, 16'd0, '0, 32'h0000_2000,
                          16'd20, 1'b0);
    dir_plan[9]  = mk_row(MODE_STATUS, REASON_FCS_BAD, 8'd0, 16'd64, '0, '0, '0, 1'b0);
    dir_plan[10] = mk_row(MODE_STATUS, REASON_BLK_DONE, 8'd8, 16'd8, '0, '0, '0, 1'b0);
    dir_plan[11] = mk_row(MODE_DATA, REASON_FCS_OK, 8'd0, 16'd0, 32'ha5a5_a5a5, '0, '0, 1'b0);
    // status arrives with one word of the block still due
    dir_plan[12] = mk_row(MODE_STATUS, REASON_FCS_OK, 8'd4, 16'd70, '0, '0, '0, 1'b0);
    dir_plan[13] = mk_row(MODE_DATA, REASON_FCS_OK, 8'd0, 16'd0, 32'h5a5a_5a5a, '0, '0, 1'b0);
    dir_plan[14] = mk_row(MODE_STATUS, REASON_BLK_DONE, 8'd4, 16'd4, '0, '0, '0, 1'b0);
    dir_plan[15] = mk_row(MODE_DATA, REASON_FCS_OK, 8'd0, 16'd0, 32'h1234_5678, '0, '0, 1'b0);
    // append past capacity
    dir_plan[16] = mk_row(MODE_STATUS, REASON_OVERRUN, 8'd17, 16'd100, '0, '0, '0, 1'b0);
    dir_plan[17] = mk_row(MODE_STATUS, REASON_FRAMING, 8'd255, 16'd65535, '0, '0, '0, 1'b0);
    dir_plan[18] = mk_row(MODE_STATUS, REASON_ODD_NYB, 8'd0, 16'd0, '0, '0, '0, 1'b0);
    dir_plan[19] = mk_row(MODE_STATUS, REASON_RSVD6, 8'd0, 16'd1, '0, '0, '0, 1'b0);
    dir_plan[20] = mk_row(MODE_STATUS, REASON_RSVD7, 8'd0, 16'd2, '0, '0, '0, 1'b0);
    dir_plan[21] = mk_row(MODE_STATUS, REASON_FCS_OK, 8'd0, 16'd0, '0, '0, '0, 1'b0);
    // restart beyond a zero-capacity head, then the pool runs dry
    dir_plan[22] = mk_row(MODE_STATUS, REASON_FCS_OK, 8'd0, 16'd3, '0, '0, '0, 1'b0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) send_item(dir_plan[i].item, dir_plan[i].quiet);

    while (n_items < ITEMS_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        case ($urandom_range(0, 3))
          0: send_item(fresh_item(MODE_DATA), 1'b0);
          1: send_item(fresh_item(MODE_UNUSED), 1'b0);
          2: begin
            it = fresh_item(MODE_STATUS);
            send_block(it.reason, it.blk_bytes, it.pkt_bytes,
                       $urandom_range(0, (it.blk_bytes + 3) / 4));
          end
          default: add_buffer();
        endcase
      end else if (sel < 15) begin
        // overfill the pool
        repeat (POOL_SLOTS + 2) add_buffer();
      end else begin
        if (!hd_present || spare_cnt < 2 || $urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 2)) add_buffer();
        nblk = $urandom_range(1, 4);
        for (int b = 0; b < nblk; b++) begin
          if (b == nblk - 1)
            rsn = ($urandom_range(0, 3) != 0) ? REASON_FCS_OK : 3'($urandom_range(1, 7));
          else
            rsn = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : REASON_BLK_DONE;
          pb = (b == 0) ? 16'($urandom_range(0, 64)) : 16'($urandom_range(65, 65535));
          cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : 0;
          send_block(rsn, pick_bytes(), pb, cut);
        end
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (rx_expected.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (rx_expected.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", rx_expected.size()));

    $display("summary: %0d items, %0d results checked, %0d words stored",
             n_items, n_results, n_stored);
    $display("summary: %0d packets delivered, %0d dropped, %0d buffers refused, %0d errors",
             n_delivered, n_dropped, n_refused, n_errors);
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ eth_rx_block_reassembly.f @@
+incdir+hdl
hdl/erbr_pkg.sv
hdl/erbr_ram.sv
hdl/erbr_pool.sv
hdl/erbr_out_buf.sv
hdl/eth_rx_block_reassembly.sv
verif/tb_top.sv
